/* rtl/core/fsfa_pkg.sv */
// Shared constants, register indexes and sequencer states for the flex sensor angle block.
package fsfa_pkg;

	localparam int CHANNELS    = 5;
	localparam int SAMPLE_BITS = 10;
	localparam int CAL_BITS    = 10;
	localparam int FRAC_BITS   = 16;
	localparam int F_BITS      = SAMPLE_BITS + FRAC_BITS;
	localparam int ALPHA_BITS  = 17;
	localparam int PACK_BITS   = CHANNELS * CAL_BITS;
	localparam int PROD_BITS   = F_BITS + ALPHA_BITS;
	localparam int CH_BITS     = 3;
	localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ANGLE_BITS  = 8;
	localparam int QUO_BITS    = 8;
	localparam int NUM_BITS    = CAL_BITS + QUO_BITS;
	localparam int CNT_BITS    = $clog2(QUO_BITS);

	localparam logic [ALPHA_BITS-1:0] ONE_Q16     = ALPHA_BITS'(65536);
	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(6554);
	localparam logic [ANGLE_BITS-1:0] MAP_LOW     = ANGLE_BITS'(50);
	localparam logic [ANGLE_BITS-1:0] MAP_HIGH    = ANGLE_BITS'(180);
	localparam logic [ANGLE_BITS-1:0] MAP_FLIP    = ANGLE_BITS'(230);
	localparam logic [ANGLE_BITS-1:0] ANGLE_TOP   = ANGLE_BITS'(230 - 50);
	localparam logic [ANGLE_BITS-1:0] ANGLE_ERR   = '0;
	localparam logic [NUM_BITS-1:0]   MAP_SPAN    = NUM_BITS'(180 - 50);

	localparam logic [1:0] CFG_ALPHA = 2'd0;
	localparam logic [1:0] CFG_MIN   = 2'd1;
	localparam logic [1:0] CFG_MAX   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_CLAMP,
		ST_MAP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/flex_sensor_filter_to_angle.sv */
// Flex sensor smoothing filter with calibrated linear map to a bend angle.
//
// Input channel: in_valid / in_stall with channel and sample. A request is
// taken when in_valid is high and in_stall low. The block works on one
// request at a time and holds in_stall high while it is busy.
// Output channel: out_valid / out_stall with out_channel and angle, driven
// from an output register, so a new request can be taken while the last
// angle still waits for the receiver.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 is alpha, 1 the packed minimums, 2 the
// packed maximums; other indexes are dropped. Write only while idle.
//
// Per request the sequencer takes it, does the alpha multiply, the filter
// update and the calibration clamp, forms the map numerator, runs an
// eight-step restoring divide (one quotient bit per cycle on a shared
// subtractor) and hands off to the output register.
// A flat or inverted calibration, or a value at the minimum, skips the
// divide; an out-of-range channel answers angle 0.
// Reset clears the seeded flags and loads the register defaults. A stalled
// receiver holds the finished angle in the sequencer until the output
// register frees up.
module flex_sensor_filter_to_angle
	import fsfa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CH_BITS-1:0]      channel,
	input  logic [SAMPLE_BITS-1:0]  sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CH_BITS-1:0]      out_channel,
	output logic [ANGLE_BITS-1:0]   angle,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [PACK_BITS-1:0]    cfg_data
);

	// Configuration registers.
	logic [ALPHA_BITS-1:0] alpha_q;
	logic [PACK_BITS-1:0]  min_q;
	logic [PACK_BITS-1:0]  max_q;

	// Per-channel filter state; the value is meaningless until seeded.
	logic [F_BITS-1:0]     filt_q [CHANNELS];
	logic [CHANNELS-1:0]   seeded_q;

	// Sequencer.
	state_t                state_q, state_nxt;
	logic [CNT_BITS-1:0]   cnt_q;

	// Request and working registers.
	logic [CH_BITS-1:0]    ch_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic                  bad_q;
	logic [CAL_BITS-1:0]   lo_q, hi_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic                  ge_q;
	logic                  seed_q;
	logic [F_BITS-1:0]     fold_q;
	logic [F_BITS-1:0]     fema_q;
	logic [SAMPLE_BITS-1:0] v_q;
	logic [CAL_BITS-1:0]   rem_q;
	logic [QUO_BITS-1:0]   dq_q;
	logic [CAL_BITS-1:0]   den_q;

	// Output register.
	logic                  out_valid_q;
	logic [CH_BITS-1:0]    out_ch_q;
	logic [ANGLE_BITS-1:0] angle_q;

	logic [CH_IDX_BITS-1:0] idx;
	logic                  accept, out_free, out_load, ch_bad, flat;
	logic [ALPHA_BITS-1:0] w;
	logic [F_BITS-1:0]     x_full, f_cur, diff;
	logic                  x_ge;
	logic [PROD_BITS:0]    prod_rnd;
	logic [F_BITS-1:0]     mag;
	logic [F_BITS-1:0]     lo_f, hi_f, f_clamp;
	logic [CAL_BITS-1:0]   span;
	logic [NUM_BITS-1:0]   num;
	logic [CAL_BITS+1:0]   trial;
	logic                  trial_ok;

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign angle       = angle_q;

	assign idx      = ch_q[CH_IDX_BITS-1:0];
	assign ch_bad   = (channel >= CH_BITS'(CHANNELS));
	assign out_free = !out_valid_q || !out_stall;

	// Alpha above one acts as one.
	assign w = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;

	// Multiply stage inputs: magnitude of the step toward the sample.
	assign x_full = {smp_q, {FRAC_BITS{1'b0}}};
	assign f_cur  = filt_q[idx];
	assign x_ge   = (x_full >= f_cur);
	assign diff   = x_ge ? (x_full - f_cur) : (f_cur - x_full);

	// Round the step up when moving down, so the filter floors toward minus infinity.
	assign prod_rnd = {1'b0, prod_q} + (PROD_BITS + 1)'((1 << FRAC_BITS) - 1);
	assign mag      = ge_q ? prod_q[FRAC_BITS +: F_BITS] : prod_rnd[FRAC_BITS +: F_BITS];

	// Clamp to calibration; the minimum test wins.
	assign lo_f = {lo_q, {FRAC_BITS{1'b0}}};
	assign hi_f = {hi_q, {FRAC_BITS{1'b0}}};
	always_comb begin
		if (fema_q <= lo_f) begin
			f_clamp = lo_f;
		end else if (fema_q >= hi_f) begin
			f_clamp = hi_f;
		end else begin
			f_clamp = fema_q;
		end
	end

	// Map numerator and divisor; v never exceeds hi, so the quotient fits eight bits.
	assign flat = (hi_q <= lo_q) || (v_q <= lo_q);
	assign span = hi_q - lo_q;
	assign num  = NUM_BITS'(v_q - lo_q) * MAP_SPAN;

	// Restoring divide step on the shared subtractor.
	assign trial    = {1'b0, rem_q, dq_q[QUO_BITS-1]} - {2'b00, den_q};
	assign trial_ok = !trial[CAL_BITS+1];

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ch_bad ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL:   state_nxt = ST_UPD;
			ST_UPD:   state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_MAP;
			ST_MAP:   state_nxt = flat ? ST_DONE : ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_BITS'(QUO_BITS - 1)) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Handshake outputs of the sequencer.
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_DONE: out_load = out_free;
			default: begin
				in_stall = 1'b1;
				out_load = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && !in_stall;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			seeded_q    <= '0;
			alpha_q     <= ALPHA_RESET;
			min_q       <= '0;
			max_q       <= '1;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else begin
				cnt_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_CLAMP) begin
				seeded_q[idx] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALPHA: alpha_q <= cfg_data[ALPHA_BITS-1:0];
					CFG_MIN:   min_q   <= cfg_data;
					CFG_MAX:   max_q   <= cfg_data;
					default:   ;
				endcase
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= channel;
			smp_q <= sample;
			bad_q <= ch_bad;
		end
		case (state_q)
			ST_MUL: begin
				lo_q   <= min_q[idx*CAL_BITS +: CAL_BITS];
				hi_q   <= max_q[idx*CAL_BITS +: CAL_BITS];
				prod_q <= PROD_BITS'(diff) * PROD_BITS'(w);
				ge_q   <= x_ge;
				fold_q <= f_cur;
				seed_q <= seeded_q[idx];
			end
			ST_UPD: begin
				if (!seed_q) begin
					fema_q <= x_full;
				end else if (ge_q) begin
					fema_q <= fold_q + mag;
				end else begin
					fema_q <= fold_q - mag;
				end
			end
			ST_CLAMP: begin
				filt_q[idx] <= f_clamp;
				v_q         <= f_clamp[FRAC_BITS +: SAMPLE_BITS];
			end
			ST_MAP: begin
				rem_q <= num[NUM_BITS-1:QUO_BITS];
				den_q <= span;
				dq_q  <= flat ? '0 : num[QUO_BITS-1:0];
			end
			ST_DIV: begin
				rem_q <= trial_ok ? trial[CAL_BITS-1:0]
				                  : {rem_q[CAL_BITS-2:0], dq_q[QUO_BITS-1]};
				dq_q  <= {dq_q[QUO_BITS-2:0], trial_ok};
			end
			default: ;
		endcase
		if (out_load) begin
			out_ch_q <= ch_q;
			angle_q  <= bad_q ? ANGLE_ERR : (ANGLE_TOP - dq_q);
		end
	end

endmodule
